// ===== sv/miller_rabin_prime_test_unit_assert.svh =====
// Assertion macros for the Miller-Rabin prime test unit.
// Depends on nothing; included by the top level.
`ifndef MILLER_RABIN_PRIME_TEST_UNIT_ASSERT_SVH
`define MILLER_RABIN_PRIME_TEST_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checked property, skipped while reset is asserted.
`define MRPT_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("mrpt assertion failed");
// Checked property, also during reset.
`define MRPT_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("mrpt assertion failed");
`else
`define MRPT_ASSERT(lbl, clk, rst_n, prop)
`define MRPT_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== sv/mrpt_pkg.sv =====
// Shared widths, verdict codes and state encoding for the prime test unit.
// Depends on nothing.
package mrpt_pkg;
	localparam int NUM_WIDTH = 62;
	localparam int CNT_W = $clog2(NUM_WIDTH + 1);
	localparam int TWOS_W = $clog2(NUM_WIDTH);

	typedef logic [NUM_WIDTH-1:0] num_t;
	typedef logic [1:0] verdict_t;

	localparam verdict_t VERDICT_PRIME = 2'd0;
	localparam verdict_t VERDICT_TRIVIAL = 2'd1;
	localparam verdict_t VERDICT_ROOT = 2'd2;
	localparam verdict_t VERDICT_FERMAT = 2'd3;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_REDUCE = 6'b000010,
		ST_SPLIT  = 6'b000100,
		ST_POW    = 6'b001000,
		ST_SQR    = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	// Handshake between the sequencer and the modular multiplier.
	typedef struct packed {
		logic start;
		num_t op_a;
		num_t op_b;
		num_t modulus;
	} mul_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		num_t product;
	} mul_rsp_t;
endpackage

// ===== sv/mrpt_cell.sv =====
// One bit cell of a right-shifting operand chain.
// Depends on nothing; used by the multiplier and the sequencer.
module mrpt_cell (
	input  logic clk,
	input  logic load,
	input  logic shift,
	input  logic load_bit,
	input  logic left_bit,
	output logic bit_q
);
	// Payload only: loaded before every use.
	always_ff @(posedge clk) begin
		if (load) begin
			bit_q <= load_bit;
		end else if (shift) begin
			bit_q <= left_bit;
		end
	end
endmodule

// ===== sv/mrpt_mulmod.sv =====
// Shift-and-add modular multiplier, one multiplier bit per cycle.
// Depends on mrpt_pkg and mrpt_cell; operands must be below the modulus.
module mrpt_mulmod (
	input  logic clk,
	input  logic arst_n,
	input  mrpt_pkg::mul_req_t req,
	output mrpt_pkg::mul_rsp_t rsp
);
	import mrpt_pkg::*;

	logic [NUM_WIDTH-1:0] b_bits;
	num_t acc_q;
	num_t a_q;
	num_t m_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic step;
	logic [NUM_WIDTH:0] sum;
	logic [NUM_WIDTH:0] sum_red;
	logic [NUM_WIDTH:0] dbl;
	logic [NUM_WIDTH:0] dbl_red;

	assign step = busy_q;

	for (genvar i = 0; i < NUM_WIDTH; i++) begin : g_b
		logic left;
		if (i == NUM_WIDTH - 1) begin : g_top
			assign left = 1'b0;
		end else begin : g_mid
			assign left = b_bits[i+1];
		end
		mrpt_cell u_cell (
			.clk(clk), .load(req.start && !busy_q), .shift(step),
			.load_bit(req.op_b[i]), .left_bit(left), .bit_q(b_bits[i])
		);
	end

	always_comb begin
		sum = {1'b0, acc_q} + (b_bits[0] ? {1'b0, a_q} : '0);
		sum_red = (sum >= {1'b0, m_q}) ? sum - {1'b0, m_q} : sum;
		dbl = {a_q, 1'b0};
		dbl_red = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_WIDTH - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			acc_q <= '0;
			a_q <= req.op_a;
			m_q <= req.modulus;
		end else if (step) begin
			acc_q <= sum_red[NUM_WIDTH-1:0];
			a_q <= dbl_red[NUM_WIDTH-1:0];
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.product = acc_q;
endmodule

// ===== sv/miller_rabin_prime_test_unit.sv =====
// Miller-Rabin prime test, one round per transaction.
// Runtime is set by the single shift-and-add multiplier, which serves every multiply.
// One transaction at a time; a held failure or trivial case goes straight to the result.
// Reset (arst_n, asynchronous) clears the held failure, the state and the output valid.
// Depends on mrpt_pkg, mrpt_cell, mrpt_mulmod and the assertion header.
`include "miller_rabin_prime_test_unit_assert.svh"
module miller_rabin_prime_test_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [61:0] candidate,
	input  logic [61:0] witness,
	input  logic last_round,
	output logic out_valid,
	input  logic out_ready,
	output logic [1:0] verdict,
	output logic test_done
);
	import mrpt_pkg::*;

	state_t state_q;
	verdict_t held_q;
	verdict_t code_q;
	logic last_q;
	num_t n_q;
	num_t w_q;
	num_t rem_q;
	num_t res_q;
	num_t sq_q;
	logic [CNT_W-1:0] cnt_q;
	logic [TWOS_W-1:0] twos_q;
	logic wait_q;
	logic tgt_q;
	logic phase_q;
	logic out_valid_q;
	verdict_t verdict_q;
	logic test_done_q;

	logic [NUM_WIDTH-1:0] e_bits;
	logic e_zero;
	logic e_load;
	logic e_shift;
	logic accept;
	num_t n_in;
	num_t w_in;
	num_t n_m1;
	logic [NUM_WIDTH:0] rem_sh;
	logic do_mult;
	mul_req_t mreq;
	mul_rsp_t mrsp;
	logic out_free;

	assign n_in = candidate[NUM_WIDTH-1:0];
	assign w_in = witness[NUM_WIDTH-1:0];
	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign n_m1 = n_q - 1'b1;
	assign rem_sh = {rem_q, w_q[NUM_WIDTH-1]};
	assign e_zero = ~|e_bits;
	assign do_mult = e_bits[0] && !phase_q;
	assign out_free = !out_valid_q || out_ready;

	// Exponent chain: loaded with n-1, shifted while stripping twos and per exponent bit.
	assign e_load = accept;
	assign e_shift = ((state_q == ST_SPLIT) && !e_bits[0]) ||
		((state_q == ST_POW) && wait_q && mrsp.done && tgt_q);

	for (genvar i = 0; i < NUM_WIDTH; i++) begin : g_e
		logic left;
		logic init;
		if (i == NUM_WIDTH - 1) begin : g_top
			assign left = 1'b0;
		end else begin : g_mid
			assign left = e_bits[i+1];
		end
		if (i == 0) begin : g_low
			assign init = 1'b0;
		end else begin : g_hi
			assign init = n_in[i];
		end
		mrpt_cell u_cell (
			.clk(clk), .load(e_load), .shift(e_shift),
			.load_bit(init), .left_bit(left), .bit_q(e_bits[i])
		);
	end

	always_comb begin
		mreq.start = 1'b0;
		mreq.op_a = res_q;
		mreq.op_b = sq_q;
		mreq.modulus = n_q;
		case (state_q)
			ST_POW: begin
				mreq.start = !wait_q && !e_zero;
				mreq.op_a = do_mult ? res_q : sq_q;
				mreq.op_b = sq_q;
			end
			ST_SQR: begin
				mreq.start = !wait_q;
				mreq.op_a = res_q;
				mreq.op_b = res_q;
			end
			default: begin
				mreq.start = 1'b0;
			end
		endcase
	end

	mrpt_mulmod u_mul (
		.clk(clk), .arst_n(arst_n), .req(mreq), .rsp(mrsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			held_q <= VERDICT_PRIME;
			wait_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					wait_q <= 1'b0;
					if (accept) begin
						if (held_q != VERDICT_PRIME) begin
							state_q <= ST_DONE;
						end else if (n_in == NUM_WIDTH'(2)) begin
							state_q <= ST_DONE;
						end else if (n_in < NUM_WIDTH'(2) || !n_in[0]) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_REDUCE;
						end
					end
				end
				ST_REDUCE: begin
					if (cnt_q == CNT_W'(NUM_WIDTH - 1)) begin
						state_q <= ST_SPLIT;
					end
				end
				ST_SPLIT: begin
					if (e_bits[0]) begin
						state_q <= ST_POW;
					end
				end
				ST_POW: begin
					if (!wait_q) begin
						if (e_zero) begin
							state_q <= (twos_q == '0) ? ST_DONE : ST_SQR;
						end else begin
							wait_q <= 1'b1;
						end
					end else if (mrsp.done) begin
						wait_q <= 1'b0;
					end
				end
				ST_SQR: begin
					if (!wait_q) begin
						wait_q <= 1'b1;
					end else if (mrsp.done) begin
						wait_q <= 1'b0;
						if (mrsp.product == NUM_WIDTH'(1) && res_q != NUM_WIDTH'(1) &&
								res_q != n_m1) begin
							state_q <= ST_DONE;
						end else if (twos_q == TWOS_W'(1)) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						held_q <= last_q ? VERDICT_PRIME : code_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					n_q <= n_in;
					w_q <= w_in;
					last_q <= last_round;
					rem_q <= '0;
					cnt_q <= '0;
					twos_q <= '0;
					phase_q <= 1'b0;
					res_q <= NUM_WIDTH'(1);
					if (held_q != VERDICT_PRIME) begin
						code_q <= held_q;
					end else if (n_in == NUM_WIDTH'(2)) begin
						code_q <= VERDICT_PRIME;
					end else if (n_in < NUM_WIDTH'(2) || !n_in[0]) begin
						code_q <= VERDICT_TRIVIAL;
					end
				end
			end
			ST_REDUCE: begin
				// Restoring remainder of the witness, one bit per cycle.
				rem_q <= (rem_sh >= {1'b0, n_q}) ? NUM_WIDTH'(rem_sh - {1'b0, n_q})
					: rem_sh[NUM_WIDTH-1:0];
				w_q <= {w_q[NUM_WIDTH-2:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
			end
			ST_SPLIT: begin
				sq_q <= rem_q;
				if (!e_bits[0]) begin
					twos_q <= twos_q + 1'b1;
				end
			end
			ST_POW: begin
				if (!wait_q) begin
					tgt_q <= !do_mult;
					if (e_zero && twos_q == '0) begin
						code_q <= (res_q != NUM_WIDTH'(1)) ? VERDICT_FERMAT : VERDICT_PRIME;
					end
				end else if (mrsp.done) begin
					if (tgt_q) begin
						sq_q <= mrsp.product;
						phase_q <= 1'b0;
					end else begin
						res_q <= mrsp.product;
						phase_q <= 1'b1;
					end
				end
			end
			ST_SQR: begin
				if (wait_q && mrsp.done) begin
					res_q <= mrsp.product;
					twos_q <= twos_q - 1'b1;
					if (mrsp.product == NUM_WIDTH'(1) && res_q != NUM_WIDTH'(1) &&
							res_q != n_m1) begin
						code_q <= VERDICT_ROOT;
					end else begin
						code_q <= (mrsp.product != NUM_WIDTH'(1)) ? VERDICT_FERMAT
							: VERDICT_PRIME;
					end
				end
			end
			ST_DONE: begin
				if (out_free) begin
					verdict_q <= code_q;
					test_done_q <= last_q;
				end
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign verdict = verdict_q;
	assign test_done = test_done_q;

	`MRPT_ASSERT(a_one_at_a_time, clk, arst_n, accept |=> !in_ready)
	`MRPT_ASSERT(a_held_reported, clk, arst_n,
		(state_q == ST_DONE && held_q != VERDICT_PRIME) |-> (code_q == held_q))
	`MRPT_ASSERT(a_mul_owner, clk, arst_n,
		mreq.start |-> (state_q == ST_POW || state_q == ST_SQR))
	`MRPT_ASSERT(a_mul_idle_start, clk, arst_n, mreq.start |-> !mrsp.busy)
	`MRPT_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |-> !out_valid)
endmodule

// ===== test/tb_miller_rabin_prime_test_unit.sv =====
// Testbench for the Miller-Rabin prime test unit: drives rounds with random idling on both
// channels and checks each verdict against a behavioral prediction. Depends on mrpt_pkg and the prime test unit.
`timescale 1ns / 100ps

module tb_miller_rabin_prime_test_unit;
	import mrpt_pkg::*;

	localparam int WATCHDOG_CYCLES = 200000;

	typedef struct packed {
		verdict_t verdict;
		logic     test_done;
	} round_result_t;

	// Tracks the held failure code and the queue of verdicts still owed by the block.
	class verdict_board;
		verdict_t held;
		round_result_t owed[$];
		int errors;

		function new();
			held = VERDICT_PRIME;
			errors = 0;
		endfunction

		function logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
			logic [63:0] acc;
			acc = '0;
			a = a % m;
			while (b != 0) begin
				if (b[0])
					acc = (acc + a) % m;
				a = (a << 1) % m;
				b = b >> 1;
			end
			return acc;
		endfunction

		function verdict_t round_verdict(logic [63:0] n, logic [63:0] a);
			logic [63:0] u, x, y, sq, e;
			int twos;
			u = n - 64'd1;
			twos = 0;
			while (!u[0]) begin
				u = u >> 1;
				twos++;
			end
			x = 64'd1;
			sq = (a % n) % n;
			e = u;
			while (e != 0) begin
				if (e[0])
					x = mulmod(x, sq, n);
				sq = mulmod(sq, sq, n);
				e = e >> 1;
			end
			for (int j = 0; j < twos; j++) begin
				y = mulmod(x, x, n);
				if (y == 1 && x != 1 && x != n - 1)
					return VERDICT_ROOT;
				x = y;
			end
			if (x != 1)
				return VERDICT_FERMAT;
			return VERDICT_PRIME;
		endfunction

		function void note_round(num_t n, num_t a, logic last);
			round_result_t r;
			logic [63:0] nn;
			nn = {2'b0, n};
			if (held == VERDICT_PRIME) begin
				if (nn == 2)
					held = VERDICT_PRIME;
				else if (nn < 2 || !nn[0])
					held = VERDICT_TRIVIAL;
				else
					held = round_verdict(nn, {2'b0, a});
			end
			r.verdict = held;
			r.test_done = last;
			owed = {owed, r};
			if (last)
				held = VERDICT_PRIME;
		endfunction

		function void check_result(verdict_t v, logic d);
			round_result_t r;
			if (owed.size() == 0) begin
				$display("%0t: unexpected result verdict=%0d test_done=%0b", $time, v, d);
				errors++;
				return;
			end
			r = owed.pop_front();
			if (r.verdict !== v) begin
				$display("%0t: verdict expected %0d actual %0d", $time, r.verdict, v);
				errors++;
			end
			if (r.test_done !== d) begin
				$display("%0t: test_done expected %0b actual %0b", $time, r.test_done, d);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [61:0] candidate, witness;
	logic last_round;
	logic [1:0] verdict;
	logic test_done;
	verdict_board board;
	int idle_cycles;

	miller_rabin_prime_test_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.candidate(candidate), .witness(witness), .last_round(last_round),
		.out_valid(out_valid), .out_ready(out_ready),
		.verdict(verdict), .test_done(test_done)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 40)
			return 0;
		if (p < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Valid stays high into the next transaction when there is no gap.
	task automatic send_round(num_t n, num_t a, logic last);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		candidate <= n;
		witness <= a;
		last_round <= last;
		do
			@(posedge clk);
		while (!in_ready);
		board.note_round(n, a, last);
	endtask

	function automatic num_t rand_num();
		num_t v;
		v = num_t'({$urandom, $urandom});
		case ($urandom_range(0, 3))
			0: v = v & 62'hFF;
			1: v = v & 62'hFFFF;
			2: v = v & 62'hFFFF_FFFF;
			default: ;
		endcase
		return v;
	endfunction

	function automatic num_t rand_odd();
		num_t v;
		v = rand_num() | 62'd1;
		if (v < 62'd3)
			v = 62'd3;
		return v;
	endfunction

	// Consumer side: random stalls, checks each accepted result.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				board.check_result(verdict, test_done);
			out_ready <= ($urandom_range(0, 9) < 7) ? 1'b1 :
				(($urandom_range(0, 19) == 0) ? 1'b0 : ($urandom_range(0, 1) == 1));
		end
	end

	// Watchdog on cycles without any transaction.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_CYCLES) begin
			$display("tb_miller_rabin_prime_test_unit NOT OK");
			$finish;
		end
	end

	initial begin
		num_t n;
		int rounds;
		board = new();
		idle_cycles = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		candidate = '0;
		witness = '0;
		last_round = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: small and extreme candidates, special witnesses, held failures.
		send_round(62'd0, 62'd1, 1'b1);
		send_round(62'd1, 62'd1, 1'b1);
		send_round(62'd2, 62'd1, 1'b1);
		send_round(62'd4, 62'd3, 1'b1);
		send_round(62'd3, 62'd2, 1'b1);
		send_round(62'd561, 62'd2, 1'b1);
		send_round(62'd341, 62'd2, 1'b1);
		send_round(62'd9, 62'd8, 1'b1);
		send_round(62'd13, 62'd0, 1'b1);
		send_round(62'd13, 62'd26, 1'b1);
		send_round(62'd97, 62'd5, 1'b0);
		send_round(62'd97, 62'd7, 1'b0);
		send_round(62'd97, 62'd11, 1'b1);
		send_round(62'd15, 62'd2, 1'b0);
		send_round(62'd13, 62'd2, 1'b0);
		send_round(62'd20, 62'd2, 1'b1);
		send_round(62'h3FFF_FFFF_FFFF_FFFF, 62'h3FFF_FFFF_FFFF_FFFE, 1'b1);
		send_round(62'h3FFF_FFFF_FFFF_FFFF, 62'h2AAA_AAAA_AAAA_AAAA, 1'b1);
		send_round(62'h3FFF_FFFF_FFFF_FFC3, 62'h1555_5555_5555_5555, 1'b1);
		send_round(62'h3FFF_FFFF_FFFF_FFFE, 62'd3, 1'b1);

		// Random tests of a few rounds each, with some noise candidates.
		rounds = 0;
		while (rounds < 80) begin
			int k;
			k = $urandom_range(1, 4);
			case ($urandom_range(0, 9))
				0: n = rand_num();
				1: n = num_t'({$urandom, $urandom});
				default: n = rand_odd();
			endcase
			for (int i = 0; i < k; i++) begin
				num_t a;
				a = ($urandom_range(0, 9) == 0) ? num_t'({$urandom, $urandom}) :
					num_t'($urandom_range(1, 1000));
				if ($urandom_range(0, 19) == 0)
					n = rand_odd();
				send_round(n, a, i == k - 1);
				rounds++;
			end
		end
		in_valid <= 1'b0;

		while (board.owed.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (board.errors == 0)
			$display("tb_miller_rabin_prime_test_unit OK");
		else
			$display("tb_miller_rabin_prime_test_unit NOT OK");
		$finish;
	end
endmodule
